FILE: rtl/lebm_pkg.sv
// ============================================================================
// lebm_pkg
// Shared constants, types and helper functions for the little-endian byte
// memory core.
// ============================================================================
package lebm_pkg;

  // Store geometry.
  localparam int MEM_BYTES  = 65536;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int LANES      = 4;
  localparam int LANE_AW    = 2;
  localparam int ROW_AW     = MEM_AW - LANE_AW;
  localparam int BANK_DEPTH = 1 << ROW_AW;

  // Field widths.
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 17;
  localparam int LIM_W  = (MEM_AW + 1 > SIZE_W + 1) ? MEM_AW + 1 : SIZE_W + 1;

  // Reset values and constants.
  localparam logic [7:0]        FILL_BYTE  = 8'hA5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
  localparam logic [LIM_W-1:0]  ROUND_ADD  = LIM_W'(15);

  // Mode codes.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Access size codes; the unused code decodes as a word.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Command to one byte lane bank.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ROW_AW-1:0] row;
    logic [7:0]        wbyte;
  } lane_cmd_t;

  // Access information carried alongside the bank read.
  typedef struct packed {
    logic               is_write;
    logic               sx;
    logic [1:0]         size;
    logic [LANE_AW-1:0] lane_off;
    logic [LANES-1:0]   byte_ok;
    logic               oor;
  } acc_info_t;

  // Effective size: rounded up to a multiple of 16, limited to the store.
  function automatic logic [LIM_W-1:0] eff_limit(input logic [SIZE_W-1:0] size);
    logic [LIM_W-1:0] s;
    s = (LIM_W'(size) + ROUND_ADD) & ~ROUND_ADD;
    if (s > LIM_W'(MEM_BYTES)) begin
      s = LIM_W'(MEM_BYTES);
    end
    return s;
  endfunction

endpackage

FILE: rtl/lebm_in_if.sv
// ============================================================================
// lebm_in_if
// Request channel: access mode, size, sign extension, address and write word.
// ============================================================================
interface lebm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [1:0]                  access_size;
  logic                        sign_extend;
  logic [lebm_pkg::ADDR_W-1:0] address;
  logic [lebm_pkg::DATA_W-1:0] write_data;

  modport source (output valid, mode, access_size, sign_extend, address, write_data,
                  input ready);
  modport sink   (input valid, mode, access_size, sign_extend, address, write_data,
                  output ready);
endinterface

FILE: rtl/lebm_out_if.sv
// ============================================================================
// lebm_out_if
// Response channel: assembled read word and out-of-range flag.
// ============================================================================
interface lebm_out_if;
  logic                        valid;
  logic                        ready;
  logic [lebm_pkg::DATA_W-1:0] read_data;
  logic                        out_of_range;

  modport source (output valid, read_data, out_of_range, input ready);
  modport sink   (input valid, read_data, out_of_range, output ready);
endinterface

FILE: rtl/lebm_bank.sv
// ============================================================================
// lebm_bank
// One byte lane of the store: single-port synchronous RAM with a registered
// read that holds its value until the next read.
// ============================================================================
module lebm_bank (
  input  logic                        clk,
  input  lebm_pkg::lane_cmd_t         cmd,
  output logic [7:0]                  rd_byte
);

  logic [7:0] mem [lebm_pkg::BANK_DEPTH];
  logic [7:0] rd_byte_r;

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[cmd.row] <= cmd.wbyte;
      end else begin
        rd_byte_r <= mem[cmd.row];
      end
    end
  end

  assign rd_byte = rd_byte_r;

endmodule

FILE: rtl/lebm_issue.sv
// ============================================================================
// lebm_issue
// Splits one access into per-byte addresses, checks each against the size in
// use and builds the command for each byte lane bank.
// ============================================================================
module lebm_issue (
  input  logic                             mode,
  input  logic [1:0]                       access_size,
  input  logic                             sign_extend,
  input  logic [lebm_pkg::ADDR_W-1:0]      address,
  input  logic [lebm_pkg::DATA_W-1:0]      write_data,
  input  logic [lebm_pkg::LIM_W-1:0]       limit,
  output lebm_pkg::lane_cmd_t [lebm_pkg::LANES-1:0] cmd,
  output lebm_pkg::acc_info_t              info
);

  logic [lebm_pkg::LANES-1:0]                       act;
  logic [lebm_pkg::LANES-1:0]                       ok;
  logic [lebm_pkg::LANES-1:0][lebm_pkg::ADDR_W-1:0] byte_addr;
  logic [lebm_pkg::LANES-1:0][lebm_pkg::LANE_AW-1:0] k_of;
  logic                                             oor;

  // Bytes touched by the access size.
  always_comb begin
    unique case (access_size)
      lebm_pkg::SZ_BYTE: act = 4'b0001;
      lebm_pkg::SZ_HALF: act = 4'b0011;
      default:           act = 4'b1111;
    endcase
  end

  // Per-byte address with 32-bit wrap and range check.
  always_comb begin
    oor = 1'b0;
    for (int k = 0; k < lebm_pkg::LANES; k++) begin
      byte_addr[k] = address + lebm_pkg::ADDR_W'(k);
      ok[k]        = act[k] && (byte_addr[k] < lebm_pkg::ADDR_W'(limit));
      oor          = oor | (act[k] & ~ok[k]);
    end
  end

  // Each lane serves the one byte whose address falls in it.
  always_comb begin
    for (int j = 0; j < lebm_pkg::LANES; j++) begin
      k_of[j]        = lebm_pkg::LANE_AW'(j) - address[lebm_pkg::LANE_AW-1:0];
      cmd[j].en      = ok[k_of[j]];
      cmd[j].we      = (mode == lebm_pkg::MODE_WRITE);
      cmd[j].row     = byte_addr[k_of[j]][lebm_pkg::MEM_AW-1:lebm_pkg::LANE_AW];
      cmd[j].wbyte   = write_data[{k_of[j], 3'b000} +: 8];
    end
  end

  assign info.is_write = (mode == lebm_pkg::MODE_WRITE);
  assign info.sx       = sign_extend;
  assign info.size     = access_size;
  assign info.lane_off = address[lebm_pkg::LANE_AW-1:0];
  assign info.byte_ok  = ok;
  assign info.oor      = oor;

endmodule

FILE: rtl/lebm_assemble.sv
// ============================================================================
// lebm_assemble
// Rotates the lane read bytes into little-endian order, zeroes bytes that
// were out of range and applies sign extension.
// ============================================================================
module lebm_assemble (
  input  lebm_pkg::acc_info_t                      info,
  input  logic [lebm_pkg::LANES-1:0][7:0]          lane_bytes,
  output logic [lebm_pkg::DATA_W-1:0]              read_data
);

  logic [lebm_pkg::LANES-1:0][7:0]          byt;
  logic [lebm_pkg::LANES-1:0][lebm_pkg::LANE_AW-1:0] lane_of;
  logic [lebm_pkg::DATA_W-1:0]              raw;

  // Byte k of the result comes from lane (offset + k).
  always_comb begin
    for (int k = 0; k < lebm_pkg::LANES; k++) begin
      lane_of[k] = info.lane_off + lebm_pkg::LANE_AW'(k);
      byt[k]     = info.byte_ok[k] ? lane_bytes[lane_of[k]] : 8'h00;
    end
  end

  assign raw = byt;

  // Sign extension of byte and halfword reads; writes return zero.
  always_comb begin
    read_data = raw;
    if (info.is_write) begin
      read_data = '0;
    end else if (info.sx && (info.size == lebm_pkg::SZ_BYTE)) begin
      read_data = {{24{byt[0][7]}}, byt[0]};
    end else if (info.sx && (info.size == lebm_pkg::SZ_HALF)) begin
      read_data = {{16{byt[1][7]}}, byt[1], byt[0]};
    end
  end

endmodule

FILE: rtl/little_endian_byte_memory_core.sv
// ============================================================================
// little_endian_byte_memory_core
// Byte-addressable little-endian memory with 1, 2 or 4 byte accesses at any
// alignment, per-byte bounds checking and optional sign extension.
// ============================================================================
//
//   Channel  Direction  Handshake     Contents
//   in_ch    input      valid/ready   mode, access_size, sign_extend, address,
//                                     write_data
//   out_ch   output     valid/ready   read_data, out_of_range
//   cfg_*    input      write enable  size in use (17 bits)
//
// One access is taken per cycle unless the clearing pass runs or a stalled
// result fills both stages; the store is split into four byte-lane banks so
// any aligned or unaligned word touches each bank at most once.
// A result passes through the bank read and then the output register.
// After reset a clearing pass fills all 16384 bank rows with 0xa5, one row
// per cycle; no request is taken until it ends.
// A stalled result holds in the output register while one more request
// proceeds into the bank stage.
// ============================================================================
module little_endian_byte_memory_core (
  input  logic                          clk,
  input  logic                          rst_n,
  lebm_in_if.sink                       in_ch,
  lebm_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lebm_pkg::SIZE_W-1:0]   cfg_wdata
);

  logic [lebm_pkg::LIM_W-1:0]  limit_r;
  logic                        clr_active_r;
  logic [lebm_pkg::ROW_AW-1:0] clr_row_r;

  lebm_pkg::lane_cmd_t [lebm_pkg::LANES-1:0] issue_cmd;
  lebm_pkg::lane_cmd_t [lebm_pkg::LANES-1:0] bank_cmd;
  lebm_pkg::acc_info_t                       issue_info;
  logic [lebm_pkg::LANES-1:0][7:0]           lane_bytes;
  logic [lebm_pkg::LANES-1:0]                issue_en;

  logic                        accept;
  logic                        s1_adv;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  lebm_pkg::acc_info_t         s1_info_r;
  logic [lebm_pkg::DATA_W-1:0] s1_rdata;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [lebm_pkg::DATA_W-1:0] out_data_r;
  logic                        out_oor_r;

  // Size register keeps the effective limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lebm_pkg::eff_limit(lebm_pkg::SIZE_RESET);
    end else if (cfg_we) begin
      limit_r <= lebm_pkg::eff_limit(cfg_wdata);
    end
  end

  // Clearing pass over every bank row after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
    end else if (clr_active_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (clr_row_r == lebm_pkg::ROW_AW'(lebm_pkg::BANK_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Request decode into lane commands.
  lebm_issue u_issue (
    .mode        (in_ch.mode),
    .access_size (in_ch.access_size),
    .sign_extend (in_ch.sign_extend),
    .address     (in_ch.address),
    .write_data  (in_ch.write_data),
    .limit       (limit_r),
    .cmd         (issue_cmd),
    .info        (issue_info)
  );

  // Handshake: the bank stage moves on when the output register is free.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign accept      = in_ch.valid && in_ch.ready;

  // Bank commands: the clearing pass or the accepted request.
  always_comb begin
    for (int j = 0; j < lebm_pkg::LANES; j++) begin
      issue_en[j] = issue_cmd[j].en;
      if (clr_active_r) begin
        bank_cmd[j].en    = 1'b1;
        bank_cmd[j].we    = 1'b1;
        bank_cmd[j].row   = clr_row_r;
        bank_cmd[j].wbyte = lebm_pkg::FILL_BYTE;
      end else begin
        bank_cmd[j]    = issue_cmd[j];
        bank_cmd[j].en = issue_cmd[j].en && accept;
      end
    end
  end

  // Byte lane banks.
  for (genvar g = 0; g < lebm_pkg::LANES; g++) begin : g_bank
    lebm_bank u_bank (
      .clk     (clk),
      .cmd     (bank_cmd[g]),
      .rd_byte (lane_bytes[g])
    );
  end

  // Bank stage control.
  assign s1_valid_nxt = accept || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= issue_info;
    end
  end

  // Word assembly from the lane read data.
  lebm_assemble u_assemble (
    .info       (s1_info_r),
    .lane_bytes (lane_bytes),
    .read_data  (s1_rdata)
  );

  // Output register.
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= s1_rdata;
      out_oor_r  <= s1_info_r.oor;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_data_r;
  assign out_ch.out_of_range = out_oor_r;

`ifndef SYNTH
  // Nothing is in flight while the banks are being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r && !out_valid_r)
    else $error("request in flight during clearing pass");

  // A stalled bank stage keeps its access information.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_info_r))
    else $error("bank stage lost its access while stalled");

  // Every in-range byte drives exactly one bank.
  a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> $countones(issue_en) == $countones(issue_info.byte_ok))
    else $error("lane enables disagree with in-range bytes");

  // Without an out-of-range byte, the bank count matches the access size.
  a_full_access: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !issue_info.oor |->
      (in_ch.access_size == lebm_pkg::SZ_BYTE && $countones(issue_en) == 1) ||
      (in_ch.access_size == lebm_pkg::SZ_HALF && $countones(issue_en) == 2) ||
      (in_ch.access_size != lebm_pkg::SZ_BYTE && in_ch.access_size != lebm_pkg::SZ_HALF &&
       $countones(issue_en) == 4))
    else $error("in-range access did not enable every byte");
`endif

endmodule
